/* sv/dpsg_pkg.sv */
// Shared types and constants for the DAC pulse sequence generator.
// No dependencies; every other file but dpsg_ram imports this package.
package dpsg_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int DAC_WIDTH   = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int POS_W       = 12;
   localparam int LOAD_ADDR_W = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // item action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_LOAD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LEVEL = 2'd2;

   // sequencer phase codes
   localparam logic [1:0] PH_PULSE = 2'd0;
   localparam logic [1:0] PH_GAP   = 2'd1;
   localparam logic [1:0] PH_RESET = 2'd2;

   localparam logic [1:0]           GROUP_END        = 2'd3;
   localparam logic [POS_W-1:0]     MAX_LEN          = POS_W'(TABLE_DEPTH);
   localparam logic [POS_W-1:0]     SEQ_LENGTH_INIT  = 12'd1;
   localparam logic [DAC_WIDTH-1:0] RESET_LEVEL_INIT = DAC_WIDTH'(-1000);

   // output queue
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0]                   action;
      logic [LOAD_ADDR_W-1:0]       load_addr;
      logic signed [DAC_WIDTH-1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic signed [DAC_WIDTH-1:0]  dac_value;
      logic                         last_of_run;
      logic                         seq_done;
   } rsp_type;

   // decision of one tick, handed from sequencer to output queue
   typedef struct packed {
      logic                         valid;       // tick produced results
      logic                         two;         // second result (0, done) follows
      logic                         from_table;  // first level comes from table read
      logic signed [DAC_WIDTH-1:0]  level;       // first level otherwise
   } push_type;

endpackage

/* sv/dpsg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module dpsg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/dpsg_ctrl.sv */
// Sequencer: configuration registers, run state, table addressing.
// Depends on dpsg_pkg.
module dpsg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  dpsg_pkg::req_type             req,
   input  logic                          csr_we,
   input  logic [dpsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpsg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                          ram_we,
   output logic [dpsg_pkg::ADDR_W-1:0]   ram_waddr,
   output logic [dpsg_pkg::DAC_WIDTH-1:0] ram_wdata,
   output logic                          ram_re,
   output logic [dpsg_pkg::ADDR_W-1:0]   ram_raddr,
   output dpsg_pkg::push_type            push
);
   import dpsg_pkg::*;

   logic                 seq_mode_ff;
   logic [POS_W-1:0]     seq_length_ff;
   logic [DAC_WIDTH-1:0] reset_level_ff;

   logic                 active_ff, active_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           group_ff, group_in;
   push_type             push_ff, push_in;

   logic [POS_W-1:0]     eff_len;
   logic [POS_W-1:0]     pos_inc;
   logic [1:0]           group_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_mode_ff    <= 1'b0;
         seq_length_ff  <= SEQ_LENGTH_INIT;
         reset_level_ff <= RESET_LEVEL_INIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEQ_MODE:    seq_mode_ff    <= csr_wdata[0];
            CSR_SEQ_LENGTH:  seq_length_ff  <= csr_wdata[POS_W-1:0];
            CSR_RESET_LEVEL: reset_level_ff <= csr_wdata[DAC_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_len = seq_length_ff;
      if (seq_length_ff == '0) begin
         eff_len = POS_W'(1);
      end else if (seq_length_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end
   end

   assign pos_inc   = position_ff + POS_W'(1);
   assign group_inc = group_ff + 2'd1;

   always_comb begin
      active_in   = active_ff;
      position_in = position_ff;
      phase_in    = phase_ff;
      group_in    = group_ff;
      push_in     = '0;
      if (accept) begin
         unique case (req.action)
            ACT_START: begin
               active_in   = 1'b1;
               position_in = '0;
               phase_in    = PH_PULSE;
               group_in    = '0;
            end
            ACT_TICK: begin
               if (active_ff) begin
                  if (!seq_mode_ff) begin
                     push_in.valid      = 1'b1;
                     push_in.from_table = 1'b1;
                     if (pos_inc >= eff_len) begin
                        push_in.two = 1'b1;
                        active_in   = 1'b0;
                        position_in = '0;
                        phase_in    = PH_PULSE;
                        group_in    = '0;
                     end else begin
                        position_in = pos_inc;
                     end
                  end else begin
                     unique case (phase_ff)
                        PH_PULSE: begin
                           push_in.valid      = 1'b1;
                           push_in.from_table = 1'b1;
                           phase_in           = PH_GAP;
                        end
                        PH_GAP: begin
                           push_in.valid = 1'b1;
                           position_in   = pos_inc;
                           if (group_inc == GROUP_END) begin
                              group_in = '0;
                              phase_in = PH_RESET;
                           end else begin
                              group_in = group_inc;
                              phase_in = (pos_inc >= eff_len) ? PH_RESET : PH_PULSE;
                           end
                        end
                        PH_RESET: begin
                           push_in.valid = 1'b1;
                           push_in.level = reset_level_ff;
                           if (position_ff >= eff_len) begin
                              push_in.two = 1'b1;
                              active_in   = 1'b0;
                              position_in = '0;
                              phase_in    = PH_PULSE;
                              group_in    = '0;
                           end else begin
                              phase_in = PH_PULSE;
                           end
                        end
                        default: begin
                           // stray phase: drop the run silently
                           active_in   = 1'b0;
                           position_in = '0;
                           phase_in    = PH_PULSE;
                           group_in    = '0;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         position_ff <= '0;
         phase_ff    <= PH_PULSE;
         group_ff    <= '0;
         push_ff     <= '0;
      end else begin
         active_ff   <= active_in;
         position_ff <= position_in;
         phase_ff    <= phase_in;
         group_ff    <= group_in;
         push_ff     <= push_in;
      end
   end

   // table read is issued with the tick; data lands next to push_ff
   assign ram_we    = accept && (req.action == ACT_LOAD);
   assign ram_waddr = req.load_addr[ADDR_W-1:0];
   assign ram_wdata = req.load_value;
   assign ram_re    = accept && (req.action == ACT_TICK);
   assign ram_raddr = position_ff[ADDR_W-1:0];
   assign push      = push_ff;

endmodule

/* sv/dpsg_outq.sv */
// Result queue: takes one or two results per tick, hands out one per transfer.
// Depends on dpsg_pkg.
module dpsg_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  dpsg_pkg::push_type            push,
   input  logic [dpsg_pkg::DAC_WIDTH-1:0] table_data,
   output logic                          room,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dpsg_pkg::rsp_type             rsp_data
);
   import dpsg_pkg::*;

   rsp_type               entry_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_W-1:0]   count_ff, count_in;
   logic [OQ_CNT_W-1:0]   n_push;
   logic                  pop;
   rsp_type               first, second;
   logic [OQ_PTR_W-1:0]   wr_ptr_nxt;

   assign n_push = push.valid ? (push.two ? OQ_CNT_W'(2) : OQ_CNT_W'(1)) : '0;
   assign pop    = rsp_valid && !rsp_stall;

   always_comb begin
      first.dac_value   = push.from_table ? table_data : push.level;
      first.last_of_run = !push.two;
      first.seq_done    = 1'b0;
      second.dac_value   = '0;
      second.last_of_run = 1'b1;
      second.seq_done    = 1'b1;
   end

   assign wr_ptr_nxt = wr_ptr_ff + OQ_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + n_push[OQ_PTR_W-1:0];
   assign rd_ptr_in  = rd_ptr_ff + OQ_PTR_W'(pop);
   assign count_in   = count_ff + n_push - OQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= first;
         if (push.two) begin
            entry_ff[wr_ptr_nxt] <= second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // space for the worst case of the next tick, ignoring this cycle's pop
   assign room      = (count_ff + n_push) <= OQ_CNT_W'(OQ_DEPTH - 2);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

endmodule

/* sv/dac_pulse_sequence_generator_top.sv */
// Top level of the table-driven DAC pulse sequence generator.
// Depends on dpsg_pkg, dpsg_ram, dpsg_ctrl and dpsg_outq.
//
//   channel | ports                          | direction | carries
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid, req_stall, req_data | in        | tick, start or table load
//   rsp     | rsp_valid, rsp_stall, rsp_data | out       | DAC level with run flags
//   csr     | csr_we, csr_index, csr_wdata   | in        | mode, length, reset level
//
// One item is taken per clock while req_stall is low. A tick's table read goes to
// the level RAM in the accept cycle; the read data and the registered decision
// arrive together in the next cycle, and the tick's results enter a four-entry
// queue at the end of it, so a result is valid on rsp once it has passed the
// decision register and the queue. A tick that ends a run adds a second result
// for its closing zero. req_stall rises when the queue, counting the results of
// the tick still on the way, holds more than two; rsp_stall only backs up that
// queue. Reset is synchronous; the level table is not cleared and holds garbage
// until loaded.
module dac_pulse_sequence_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dpsg_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dpsg_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [dpsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpsg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dpsg_pkg::*;

   logic                 accept;
   logic                 room;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [DAC_WIDTH-1:0] ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [DAC_WIDTH-1:0] ram_rdata;
   push_type             push;

   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   dpsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .push      (push)
   );

   // level table
   dpsg_ram #(
      .WIDTH (DAC_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_level_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dpsg_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .table_data (ram_rdata),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* verif/tb_dac_pulse_sequence_generator_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dac_pulse_sequence_generator_top.
// Depends on dpsg_pkg and the RTL. A scoreboard class predicts every DAC write.
module tb_dac_pulse_sequence_generator_top;
   import dpsg_pkg::*;

   // action code the block must ignore, register index with no register behind it
   localparam logic [1:0]           ACT_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;

   localparam int TARGET_ITEMS  = 1900;     // effective transfers before stimulus stops
   localparam int SETTLE_CYCLES = 8;        // pipeline is two deep plus closing zero
   localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_REPORTS   = 10;

   // -----------------------------------------------------------------------
   // Scoreboard: own copy of the sequencer state and registers. take_item is
   // called for every accepted request transfer and queues the DAC writes it
   // causes; check_write compares one accepted response with the oldest one.
   // -----------------------------------------------------------------------
   class pulse_scoreboard;
      bit                          mode_q;
      logic [POS_W-1:0]            length_q;
      logic signed [DAC_WIDTH-1:0] reset_level_q;
      bit                          running;
      logic [POS_W-1:0]            pos;
      logic [1:0]                  phase;
      logic [1:0]                  grp_count;
      logic signed [DAC_WIDTH-1:0] levels [TABLE_DEPTH];
      bit                          loaded [TABLE_DEPTH];
      rsp_type                     dac_writes_due [$];
      int n_loads, n_starts, n_ticks, n_effective;
      int n_checked, n_errors, runs_plain, runs_pulsed;

      function new();
         mode_q        = 1'b0;
         length_q      = SEQ_LENGTH_INIT;
         reset_level_q = RESET_LEVEL_INIT;
         end_run();
      endfunction

      function void end_run();
         running   = 1'b0;
         pos       = '0;
         phase     = PH_PULSE;
         grp_count = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SEQ_MODE:    mode_q        = data[0];
            CSR_SEQ_LENGTH:  length_q      = data[POS_W-1:0];
            CSR_RESET_LEVEL: reset_level_q = data[DAC_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, anything past the table saturates
      function int play_length();
         int n;
         n = int'(length_q);
         if (n == 0) n = 1;
         if (n > TABLE_DEPTH) n = TABLE_DEPTH;
         return n;
      endfunction

      // table entry the next tick would read, if any
      function bit next_read(output int idx);
         idx = int'(pos) % TABLE_DEPTH;
         return running && (!mode_q || phase == PH_PULSE);
      endfunction

      function void queue_write(logic signed [DAC_WIDTH-1:0] level, bit last, bit done);
         rsp_type w;
         w.dac_value   = level;
         w.last_of_run = last;
         w.seq_done    = done;
         dac_writes_due.push_back(w);
      endfunction

      function void take_item(req_type r);
         int n;
         logic signed [DAC_WIDTH-1:0] lv;
         n = play_length();
         case (r.action)
            ACT_LOAD: begin
               levels[int'(r.load_addr) % TABLE_DEPTH] = r.load_value;
               loaded[int'(r.load_addr) % TABLE_DEPTH] = 1'b1;
               n_loads++;
               n_effective++;
            end
            ACT_START: begin
               end_run();
               running = 1'b1;
               n_starts++;
               n_effective++;
            end
            ACT_TICK: begin
               if (!running) return;
               n_ticks++;
               n_effective++;
               if (!mode_q) begin
                  lv  = levels[int'(pos) % TABLE_DEPTH];
                  pos = pos + 1'b1;
                  if (int'(pos) >= n) begin
                     queue_write(lv, 1'b0, 1'b0);
                     queue_write('0, 1'b1, 1'b1);
                     end_run();
                     runs_plain++;
                  end else begin
                     queue_write(lv, 1'b1, 1'b0);
                  end
               end else begin
                  case (phase)
                     PH_PULSE: begin
                        queue_write(levels[int'(pos) % TABLE_DEPTH], 1'b1, 1'b0);
                        phase = PH_GAP;
                     end
                     PH_GAP: begin
                        queue_write('0, 1'b1, 1'b0);
                        pos       = pos + 1'b1;
                        grp_count = grp_count + 1'b1;
                        if (grp_count >= GROUP_END) begin
                           grp_count = '0;
                           phase     = PH_RESET;
                        end else if (int'(pos) >= n) begin
                           phase = PH_RESET;
                        end else begin
                           phase = PH_PULSE;
                        end
                     end
                     PH_RESET: begin
                        if (int'(pos) >= n) begin
                           queue_write(reset_level_q, 1'b0, 1'b0);
                           queue_write('0, 1'b1, 1'b1);
                           end_run();
                           runs_pulsed++;
                        end else begin
                           queue_write(reset_level_q, 1'b1, 1'b0);
                           phase = PH_PULSE;
                        end
                     end
                     default: end_run();
                  endcase
               end
            end
            default: ;
         endcase
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("mismatch (%s) at DAC write %0d: expected level %0d last %0b done %0b,",
                     what, n_checked, want.dac_value, want.last_of_run, want.seq_done,
                     " got level %0d last %0b done %0b",
                     got.dac_value, got.last_of_run, got.seq_done);
      endfunction

      function void check_write(rsp_type got);
         rsp_type want;
         n_checked++;
         if (dac_writes_due.size() == 0) begin
            want = '0;
            flag("no write due", want, got);
            return;
         end
         want = dac_writes_due.pop_front();
         if (got.dac_value !== want.dac_value || got.last_of_run !== want.last_of_run ||
             got.seq_done !== want.seq_done)
            flag("wrong field", want, got);
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Clock, reset and DUT
   // -----------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pulse_scoreboard sb;
   bit calm;                 // when set neither side inserts idle cycles
   int hold_requests;        // bumped by the stimulus to ask for a hold-off
   int holds_taken;
   int hold_left;
   int rsp_wait;
   int cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dac_pulse_sequence_generator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -----------------------------------------------------------------------
   // Response side: check each transfer, then draw how many cycles to stall
   // before the next one. A hold-off request keeps stall up for HOLD_CYCLES
   // so the output queue fills and the block has to stall its request side.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_write(rsp_data);
            rsp_wait = calm ? 0 : $urandom_range(0, 6);
         end
         if (holds_taken != hold_requests) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d DAC writes still due",
                  cycles, sb.dac_writes_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Request side
   // -----------------------------------------------------------------------
   function automatic req_type make_req(input logic [1:0] act, input int addr,
                                        input logic [DAC_WIDTH-1:0] val);
      req_type r;
      r.action     = act;
      r.load_addr  = LOAD_ADDR_W'(addr);
      r.load_value = val;
      return r;
   endfunction

   // levels biased toward the extremes
   function automatic logic [DAC_WIDTH-1:0] rand_level();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return '0;
         3: return '1;
         default: return DAC_WIDTH'($urandom);
      endcase
   endfunction

   // One request transfer: optional idle gap, then hold valid and payload
   // until the block takes it. Valid stays high across back-to-back items.
   task automatic send_item(input req_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      sb.take_item(it);
   endtask

   // A tick never reads a table entry that was never loaded: load it first.
   task automatic send_tick();
      int idx;
      if (sb.next_read(idx) && !sb.loaded[idx])
         send_item(make_req(ACT_LOAD, idx, rand_level()));
      send_item(make_req(ACT_TICK, $urandom_range(0, TABLE_DEPTH - 1), DAC_WIDTH'($urandom)));
   endtask

   task automatic send_start();
      send_item(make_req(ACT_START, $urandom_range(0, TABLE_DEPTH - 1), DAC_WIDTH'($urandom)));
   endtask

   // drain: no write due, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.dac_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // all three registers, junk in the unused upper bits
   task automatic configure(input bit mode, input int len, input logic [DAC_WIDTH-1:0] level,
                            input bit poke_unused);
      settle();
      if (poke_unused) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_reg(CSR_SEQ_MODE, {15'($urandom), mode});
      write_reg(CSR_SEQ_LENGTH, {4'($urandom), POS_W'(len)});
      write_reg(CSR_RESET_LEVEL, level);
      csr_we <= 1'b0;
   endtask

   // tick until the run ends, with stray loads, ignored codes and restarts
   task automatic play_run();
      while (sb.running) begin
         case ($urandom_range(0, 19))
            0: send_item(make_req(ACT_LOAD, $urandom_range(0, TABLE_DEPTH - 1), rand_level()));
            1: send_item(make_req(ACT_UNUSED, $urandom_range(0, TABLE_DEPTH - 1),
                                  DAC_WIDTH'($urandom)));
            2: begin
               if ($urandom_range(0, 3) == 0) send_start();
            end
            default: send_tick();
         endcase
      end
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return $urandom_range(2, 3);
         9: return $urandom_range(13, 40);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------
   initial begin
      int phase_no;
      int len;
      bit mode;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: plain, length 1, reset level -1000
      send_item(make_req(ACT_LOAD, 0, 16'h7FFF));
      send_start();
      send_tick();                                   // word, then closing zero
      send_tick();                                   // idle: no write
      send_item(make_req(ACT_UNUSED, TABLE_DEPTH - 1, 16'hFFFF));

      // pulsed with the reset-value reset level; unused register index poked
      settle();
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_reg(CSR_SEQ_MODE, {15'($urandom), 1'b1});
      csr_we <= 1'b0;
      send_item(make_req(ACT_LOAD, TABLE_DEPTH - 1, 16'h8000));
      send_start();
      repeat (3) send_tick();

      // length zero acts as one
      configure(1'b1, 0, 16'h7FFF, 1'b0);
      send_start();
      repeat (3) send_tick();

      // length not a multiple of three: reset after third pulse and at end
      configure(1'b1, 4, 16'h8000, 1'b0);
      send_item(make_req(ACT_LOAD, 1, 16'h8000));
      send_item(make_req(ACT_LOAD, 2, 16'hFFFF));
      send_item(make_req(ACT_LOAD, 3, 16'h5555));
      send_start();
      while (sb.running) send_tick();

      // random phases: mostly complete runs, some with mid-run reprogramming
      phase_no = 0;
      while (sb.n_effective < TARGET_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         mode = 1'($urandom_range(0, 1));
         if (phase_no % 8 == 3) begin
            // long run, then length lowered and mode maybe flipped while active
            case ($urandom_range(0, 2))
               0: len = TABLE_DEPTH;
               1: len = 4095;
               default: len = $urandom_range(100, 300);
            endcase
            configure(mode, len, rand_level(), 1'b0);
            send_start();
            repeat ($urandom_range(5, 25)) send_tick();
            configure(1'($urandom_range(0, 1)), $urandom_range(0, 6), rand_level(), 1'b0);
            play_run();
         end else begin
            len = pick_length();
            if (phase_no % 25 == 10) len = 40;
            configure(mode, len, rand_level(), phase_no % 16 == 0);
            if (phase_no % 25 == 10) hold_requests++;
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(0, 3))
                  send_item(make_req(ACT_LOAD, $urandom_range(0, len), rand_level()));
               if ($urandom_range(0, 2) == 0)
                  send_item(make_req(ACT_LOAD, $urandom_range(0, TABLE_DEPTH - 1),
                                     rand_level()));
               send_start();
               play_run();
               if ($urandom_range(0, 3) == 0) send_tick();    // tick while idle
            end
         end
         phase_no++;
      end

      calm = 1'b0;
      settle();
      $display("summary: %0d loads, %0d starts, %0d active ticks; %0d DAC writes checked",
               sb.n_loads, sb.n_starts, sb.n_ticks, sb.n_checked);
      $display("summary: %0d plain and %0d pulsed runs ended, %0d hold-offs, %0d mismatches",
               sb.runs_plain, sb.runs_pulsed, holds_taken, sb.n_errors);
      if (sb.n_errors == 0 && sb.dac_writes_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
